FILE: sv/sawarq_pkg.sv
package sawarq_pkg;

    localparam int TIME_W     = 16;
    localparam int SEQ_W      = 32;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = FIFO_AW + 1;

    localparam logic [TIME_W-1:0] INIT_TIMEOUT_RST = TIME_W'(1000);

    typedef logic [1:0] t_opcode;
    localparam t_opcode OP_SEND = 2'd0;
    localparam t_opcode OP_PKT  = 2'd1;
    localparam t_opcode OP_TICK = 2'd2;
    localparam t_opcode OP_RECV = 2'd3;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_SEGMENT = 2'd0;
    localparam t_kind KIND_ACK     = 2'd1;
    localparam t_kind KIND_DONE    = 2'd2;
    localparam t_kind KIND_DELIVER = 2'd3;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'b001,
        MODE_SEND = 3'b010,
        MODE_RECV = 3'b100
    } t_mode;

    typedef struct packed {
        t_opcode            opcode;
        logic [SEQ_W-1:0]   pkt_seq;
        logic [SEQ_W-1:0]   pkt_ack;
        logic               pkt_ack_flag;
        logic               pkt_fin_flag;
        logic               pkt_short;
        logic               want_fin;
    } t_item;

    typedef struct packed {
        t_kind              kind;
        logic [SEQ_W-1:0]   out_seq;
        logic [SEQ_W-1:0]   out_ack;
        logic               out_ack_flag;
        logic               out_fin_flag;
        logic [TIME_W-1:0]  rtt_now;
        logic [TIME_W-1:0]  timeout_now;
        logic               peer_done;
        logic               last_result;
    } t_result;

endpackage

FILE: sv/stop_and_wait_arq_endpoint.sv
// throughput: one event per cycle while o_ready is high, set by the
// single-pass update of the state registers; each event yields up to two
// results into an eight-entry queue
// reset: synchronous active-low i_rst_n clears mode, sequence numbers, rtt state
// and the result queue; initial timeout returns to 1000 ms
module stop_and_wait_arq_endpoint import sawarq_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [TIME_W-1:0] i_cfg_wr_data,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_opcode,
    input  logic [SEQ_W-1:0]  i_pkt_seq,
    input  logic [SEQ_W-1:0]  i_pkt_ack,
    input  logic              i_pkt_ack_flag,
    input  logic              i_pkt_fin_flag,
    input  logic              i_pkt_short,
    input  logic              i_want_fin,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [1:0]        o_kind,
    output logic [SEQ_W-1:0]  o_out_seq,
    output logic [SEQ_W-1:0]  o_out_ack,
    output logic              o_out_ack_flag,
    output logic              o_out_fin_flag,
    output logic [TIME_W-1:0] o_rtt_now,
    output logic [TIME_W-1:0] o_timeout_now,
    output logic              o_peer_done,
    output logic              o_last_result
);

    logic [TIME_W-1:0]  r_init_timeout;
    logic               r_in_v;
    t_item              r_in;

    t_mode              r_mode,        n_mode;
    logic [SEQ_W-1:0]   r_send_seq,    n_send_seq;
    logic [SEQ_W-1:0]   r_expect_seq,  n_expect_seq;
    logic [TIME_W-1:0]  r_rtt_est,     n_rtt_est;
    logic [TIME_W-1:0]  r_rtt_dev,     n_rtt_dev;
    logic [1:0]         r_warm,        n_warm;
    logic               r_retx,        n_retx;
    logic [TIME_W-1:0]  r_time_left,   n_time_left;
    logic [TIME_W-1:0]  r_interval,    n_interval;
    logic               r_pend_fin,    n_pend_fin;
    logic               r_peer_closed, n_peer_closed;

    t_result            r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [FIFO_CW-1:0] r_count;

    t_result            n_res0, n_res1;
    logic [1:0]         n_res_cnt;

    logic               in_accept, out_accept;
    logic [SEQ_W-1:0]   prev_seq;
    logic [TIME_W-1:0]  sample, est_base, abs_diff, n_est_upd, n_dev_upd;
    logic [TIME_W+2:0]  est_sum, rto_sum;
    logic [TIME_W+1:0]  dev_sum;
    logic [TIME_W-1:0]  rto_sat;
    logic [FIFO_CW:0]   room_need;

    // admit a transaction only if the queue can absorb two results for it and
    // for the one still in the input register
    assign room_need  = {1'b0, r_count} + (r_in_v ? (FIFO_CW+1)'(2) : '0);
    assign o_ready    = room_need <= (FIFO_CW+1)'(FIFO_DEPTH - 2);
    assign in_accept  = i_valid && o_ready;
    assign o_valid    = r_count != '0;
    assign out_accept = o_valid && i_ready;

    assign prev_seq = r_expect_seq - SEQ_W'(1);

    // jacobson update: new estimate first, deviation against the new estimate
    assign sample    = r_interval - r_time_left;
    assign est_base  = (r_warm == 2'd0) ? sample : r_rtt_est;
    assign est_sum   = ({3'b0, est_base} << 3) - {3'b0, est_base} + {3'b0, sample};
    assign n_est_upd = est_sum[TIME_W+2:3];
    assign abs_diff  = (sample >= n_est_upd) ? sample - n_est_upd : n_est_upd - sample;
    assign dev_sum   = ({2'b0, r_rtt_dev} << 1) + {2'b0, r_rtt_dev} + {2'b0, abs_diff};
    assign n_dev_upd = dev_sum[TIME_W+1:2];

    assign rto_sum = {3'b0, r_rtt_est} + {1'b0, r_rtt_dev, 2'b0};
    assign rto_sat = (rto_sum[TIME_W+2:TIME_W] != '0) ? '1 : rto_sum[TIME_W-1:0];

    always_comb begin
        n_mode        = r_mode;
        n_send_seq    = r_send_seq;
        n_expect_seq  = r_expect_seq;
        n_rtt_est     = r_rtt_est;
        n_rtt_dev     = r_rtt_dev;
        n_warm        = r_warm;
        n_retx        = r_retx;
        n_time_left   = r_time_left;
        n_interval    = r_interval;
        n_pend_fin    = r_pend_fin;
        n_peer_closed = r_peer_closed;
        n_res0        = '0;
        n_res1        = '0;
        n_res_cnt     = 2'd0;

        if (r_in_v) begin
            unique case (r_in.opcode)
                OP_SEND: begin
                    if (r_mode == MODE_IDLE) begin
                        n_interval   = r_warm[1] ? rto_sat : r_init_timeout;
                        n_time_left  = n_interval;
                        n_retx       = 1'b0;
                        n_pend_fin   = r_in.want_fin;
                        n_mode       = MODE_SEND;
                        n_res0.kind         = KIND_SEGMENT;
                        n_res0.out_seq      = r_send_seq;
                        n_res0.out_ack      = r_expect_seq;
                        n_res0.out_fin_flag = r_in.want_fin;
                        n_res_cnt    = 2'd1;
                    end
                end
                OP_RECV: begin
                    if (r_mode == MODE_IDLE) begin
                        n_pend_fin = r_in.want_fin;
                        n_mode     = MODE_RECV;
                    end
                end
                OP_TICK: begin
                    if (r_mode == MODE_SEND) begin
                        if (r_time_left > TIME_W'(1)) begin
                            n_time_left = r_time_left - TIME_W'(1);
                        end else begin
                            n_retx      = 1'b1;
                            n_time_left = r_interval;
                            n_res0.kind         = KIND_SEGMENT;
                            n_res0.out_seq      = r_send_seq;
                            n_res0.out_ack      = r_expect_seq;
                            n_res0.out_fin_flag = r_pend_fin;
                            n_res_cnt   = 2'd1;
                        end
                    end
                end
                OP_PKT: begin
                    if (r_mode == MODE_SEND) begin
                        if (r_in.pkt_ack_flag && r_in.pkt_ack == r_send_seq) begin
                            // karn: no sample from a retransmitted segment
                            if (!r_retx) begin
                                n_rtt_est = n_est_upd;
                                n_rtt_dev = n_dev_upd;
                                if (r_warm != 2'd2) begin
                                    n_warm = r_warm + 2'd1;
                                end
                            end
                            n_time_left = '0;
                            n_mode      = MODE_IDLE;
                            n_send_seq  = r_send_seq + SEQ_W'(1);
                            n_res0.kind = KIND_DONE;
                            n_res_cnt   = 2'd1;
                        end else if (r_in.pkt_seq == prev_seq) begin
                            n_res0.kind         = KIND_ACK;
                            n_res0.out_seq      = r_send_seq;
                            n_res0.out_ack      = prev_seq;
                            n_res0.out_ack_flag = 1'b1;
                            n_res_cnt   = 2'd1;
                        end
                    end else if (r_mode == MODE_RECV && !r_in.pkt_short) begin
                        n_res0.kind         = KIND_ACK;
                        n_res0.out_seq      = r_send_seq;
                        n_res0.out_ack_flag = 1'b1;
                        if (r_in.pkt_seq == r_expect_seq && (!r_pend_fin || r_in.pkt_fin_flag)) begin
                            n_res0.out_ack = r_expect_seq;
                            n_res1.kind    = KIND_DELIVER;
                            n_res_cnt      = 2'd2;
                            n_peer_closed  = r_peer_closed | r_in.pkt_fin_flag;
                            n_expect_seq   = r_expect_seq + SEQ_W'(1);
                            n_mode         = MODE_IDLE;
                        end else begin
                            n_res0.out_ack = prev_seq;
                            n_res_cnt      = 2'd1;
                        end
                    end
                end
                default: ;
            endcase
        end

        // status fields reflect the state after this event
        n_res0.rtt_now     = n_rtt_est;
        n_res0.timeout_now = n_interval;
        n_res0.peer_done   = n_peer_closed;
        n_res0.last_result = n_res_cnt == 2'd1;
        n_res1.rtt_now     = n_rtt_est;
        n_res1.timeout_now = n_interval;
        n_res1.peer_done   = n_peer_closed;
        n_res1.last_result = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_timeout <= INIT_TIMEOUT_RST;
            r_in_v         <= 1'b0;
            r_mode         <= MODE_IDLE;
            r_send_seq     <= '0;
            r_expect_seq   <= '0;
            r_rtt_est      <= '0;
            r_rtt_dev      <= '0;
            r_warm         <= '0;
            r_retx         <= 1'b0;
            r_time_left    <= '0;
            r_interval     <= '0;
            r_pend_fin     <= 1'b0;
            r_peer_closed  <= 1'b0;
            r_wr_ptr       <= '0;
            r_rd_ptr       <= '0;
            r_count        <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_init_timeout <= i_cfg_wr_data;
            end
            r_in_v        <= in_accept;
            r_mode        <= n_mode;
            r_send_seq    <= n_send_seq;
            r_expect_seq  <= n_expect_seq;
            r_rtt_est     <= n_rtt_est;
            r_rtt_dev     <= n_rtt_dev;
            r_warm        <= n_warm;
            r_retx        <= n_retx;
            r_time_left   <= n_time_left;
            r_interval    <= n_interval;
            r_pend_fin    <= n_pend_fin;
            r_peer_closed <= n_peer_closed;
            r_wr_ptr      <= r_wr_ptr + FIFO_AW'(n_res_cnt);
            if (out_accept) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            r_count <= r_count + FIFO_CW'(n_res_cnt) - FIFO_CW'(out_accept);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in.opcode       <= i_opcode;
            r_in.pkt_seq      <= i_pkt_seq;
            r_in.pkt_ack      <= i_pkt_ack;
            r_in.pkt_ack_flag <= i_pkt_ack_flag;
            r_in.pkt_fin_flag <= i_pkt_fin_flag;
            r_in.pkt_short    <= i_pkt_short;
            r_in.want_fin     <= i_want_fin;
        end
        if (n_res_cnt != 2'd0) begin
            r_fifo[r_wr_ptr] <= n_res0;
        end
        if (n_res_cnt == 2'd2) begin
            r_fifo[r_wr_ptr + FIFO_AW'(1)] <= n_res1;
        end
    end

    assign o_kind         = r_fifo[r_rd_ptr].kind;
    assign o_out_seq      = r_fifo[r_rd_ptr].out_seq;
    assign o_out_ack      = r_fifo[r_rd_ptr].out_ack;
    assign o_out_ack_flag = r_fifo[r_rd_ptr].out_ack_flag;
    assign o_out_fin_flag = r_fifo[r_rd_ptr].out_fin_flag;
    assign o_rtt_now      = r_fifo[r_rd_ptr].rtt_now;
    assign o_timeout_now  = r_fifo[r_rd_ptr].timeout_now;
    assign o_peer_done    = r_fifo[r_rd_ptr].peer_done;
    assign o_last_result  = r_fifo[r_rd_ptr].last_result;

endmodule

FILE: test/stop_and_wait_arq_endpoint_tb.sv
module stop_and_wait_arq_endpoint_tb import sawarq_pkg::*; ();

    localparam int MAX_REPORTS = 10;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    typedef struct {
        bit                is_cfg;
        logic [TIME_W-1:0] cfg_val;
        t_item             ev;
        bit                typed;
        t_result           want;
    } t_script_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_wr_en;
    logic [TIME_W-1:0] i_cfg_wr_data;
    logic              i_valid;
    logic              o_ready;
    logic [1:0]        i_opcode;
    logic [SEQ_W-1:0]  i_pkt_seq;
    logic [SEQ_W-1:0]  i_pkt_ack;
    logic              i_pkt_ack_flag;
    logic              i_pkt_fin_flag;
    logic              i_pkt_short;
    logic              i_want_fin;
    logic              o_valid;
    logic              i_ready;
    logic [1:0]        o_kind;
    logic [SEQ_W-1:0]  o_out_seq;
    logic [SEQ_W-1:0]  o_out_ack;
    logic              o_out_ack_flag;
    logic              o_out_fin_flag;
    logic [TIME_W-1:0] o_rtt_now;
    logic [TIME_W-1:0] o_timeout_now;
    logic              o_peer_done;
    logic              o_last_result;

    // endpoint state as the predictor sees it
    t_mode             ep_mode;
    logic [SEQ_W-1:0]  ep_send_seq;
    logic [SEQ_W-1:0]  ep_expect_seq;
    logic [TIME_W-1:0] ep_srtt;
    logic [TIME_W-1:0] ep_rttvar;
    logic [TIME_W-1:0] ep_time_left;
    logic [TIME_W-1:0] ep_interval;
    logic [TIME_W-1:0] ep_init_timeout;
    logic [1:0]        ep_samples;
    logic              ep_retx;
    logic              ep_fin;
    logic              ep_peer_closed;

    t_result     due_results[$];
    t_script_row script[$];
    int          mismatches = 0;
    int          acted_events = 0;
    bit          in_calm = 1'b0;
    bit          out_calm = 1'b0;

    stop_and_wait_arq_endpoint dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_opcode       (i_opcode),
        .i_pkt_seq      (i_pkt_seq),
        .i_pkt_ack      (i_pkt_ack),
        .i_pkt_ack_flag (i_pkt_ack_flag),
        .i_pkt_fin_flag (i_pkt_fin_flag),
        .i_pkt_short    (i_pkt_short),
        .i_want_fin     (i_want_fin),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_kind         (o_kind),
        .o_out_seq      (o_out_seq),
        .o_out_ack      (o_out_ack),
        .o_out_ack_flag (o_out_ack_flag),
        .o_out_fin_flag (o_out_fin_flag),
        .o_rtt_now      (o_rtt_now),
        .o_timeout_now  (o_timeout_now),
        .o_peer_done    (o_peer_done),
        .o_last_result  (o_last_result)
    );

    always #6 i_clk = ~i_clk;

    function automatic t_result header(input t_kind k, input logic [SEQ_W-1:0] sq,
                                       input logic [SEQ_W-1:0] ak, input logic af,
                                       input logic ff);
        t_result r;
        r = '0;
        r.kind         = k;
        r.out_seq      = sq;
        r.out_ack      = ak;
        r.out_ack_flag = af;
        r.out_fin_flag = ff;
        return r;
    endfunction

    function automatic t_result typed_result(input t_kind k, input logic [SEQ_W-1:0] sq,
                                             input logic [SEQ_W-1:0] ak, input logic af,
                                             input logic ff, input logic [TIME_W-1:0] rtt,
                                             input logic [TIME_W-1:0] rto, input logic peer);
        t_result r;
        r = header(k, sq, ak, af, ff);
        r.rtt_now     = rtt;
        r.timeout_now = rto;
        r.peer_done   = peer;
        r.last_result = 1'b1;
        return r;
    endfunction

    function automatic string show(input t_result r);
        return $sformatf("kind=%0d seq=%h ack=%h aflag=%b fin=%b rtt=%0d rto=%0d peer=%b last=%b",
                         r.kind, r.out_seq, r.out_ack, r.out_ack_flag, r.out_fin_flag,
                         r.rtt_now, r.timeout_now, r.peer_done, r.last_result);
    endfunction

    // works out the results of one accepted event and queues them
    task automatic predict_event(input t_item ev, input bit typed, input t_result want,
                                 output bit acted);
        t_result           res [2];
        int                n;
        logic [SEQ_W-1:0]  prev;
        logic [TIME_W-1:0] sample;
        logic [TIME_W-1:0] diff;
        logic [TIME_W+3:0] acc;
        n = 0;
        acted = 1'b1;
        prev = ep_expect_seq - 1'b1;
        case (ev.opcode)
            OP_SEND: begin
                if (ep_mode != MODE_IDLE) begin
                    acted = 1'b0;
                end else begin
                    if (ep_samples < 2) begin
                        ep_interval = ep_init_timeout;
                    end else begin
                        acc = {4'b0, ep_srtt} + {2'b0, ep_rttvar, 2'b0};
                        ep_interval = (acc > TIME_MAX) ? TIME_MAX : acc[TIME_W-1:0];
                    end
                    ep_time_left = ep_interval;
                    ep_retx = 1'b0;
                    ep_fin = ev.want_fin;
                    ep_mode = MODE_SEND;
                    res[0] = header(KIND_SEGMENT, ep_send_seq, ep_expect_seq, 1'b0, ep_fin);
                    n = 1;
                end
            end
            OP_RECV: begin
                if (ep_mode != MODE_IDLE) begin
                    acted = 1'b0;
                end else begin
                    ep_fin = ev.want_fin;
                    ep_mode = MODE_RECV;
                end
            end
            OP_TICK: begin
                if (ep_mode != MODE_SEND) begin
                    acted = 1'b0;
                end else if (ep_time_left > 1) begin
                    ep_time_left = ep_time_left - 1'b1;
                end else begin
                    ep_retx = 1'b1;
                    ep_time_left = ep_interval;
                    res[0] = header(KIND_SEGMENT, ep_send_seq, ep_expect_seq, 1'b0, ep_fin);
                    n = 1;
                end
            end
            default: begin
                if (ep_mode == MODE_SEND) begin
                    if (ev.pkt_ack_flag && ev.pkt_ack == ep_send_seq) begin
                        // karn: no sample from a segment that went out twice
                        if (!ep_retx) begin
                            sample = ep_interval - ep_time_left;
                            if (ep_samples == 0) begin
                                ep_samples = 2'd1;
                                ep_srtt = sample;
                            end else if (ep_samples == 1) begin
                                ep_samples = 2'd2;
                            end
                            acc = ({4'b0, ep_srtt} * (TIME_W+4)'(7) + {4'b0, sample}) >> 3;
                            ep_srtt = acc[TIME_W-1:0];
                            diff = (sample >= ep_srtt) ? sample - ep_srtt : ep_srtt - sample;
                            acc = ({4'b0, ep_rttvar} * (TIME_W+4)'(3) + {4'b0, diff}) >> 2;
                            ep_rttvar = acc[TIME_W-1:0];
                        end
                        ep_time_left = '0;
                        ep_mode = MODE_IDLE;
                        ep_send_seq = ep_send_seq + 1'b1;
                        res[0] = header(KIND_DONE, '0, '0, 1'b0, 1'b0);
                        n = 1;
                    end else if (ev.pkt_seq == prev) begin
                        res[0] = header(KIND_ACK, ep_send_seq, prev, 1'b1, 1'b0);
                        n = 1;
                    end else begin
                        acted = 1'b0;
                    end
                end else if (ep_mode == MODE_RECV) begin
                    if (ev.pkt_short) begin
                        acted = 1'b0;
                    end else if (ev.pkt_seq == ep_expect_seq && (!ep_fin || ev.pkt_fin_flag)) begin
                        res[0] = header(KIND_ACK, ep_send_seq, ep_expect_seq, 1'b1, 1'b0);
                        res[1] = header(KIND_DELIVER, '0, '0, 1'b0, 1'b0);
                        if (ev.pkt_fin_flag) ep_peer_closed = 1'b1;
                        ep_expect_seq = ep_expect_seq + 1'b1;
                        ep_mode = MODE_IDLE;
                        n = 2;
                    end else begin
                        res[0] = header(KIND_ACK, ep_send_seq, prev, 1'b1, 1'b0);
                        n = 1;
                    end
                end else begin
                    acted = 1'b0;
                end
            end
        endcase
        for (int k = 0; k < n; k++) begin
            res[k].rtt_now     = ep_srtt;
            res[k].timeout_now = ep_interval;
            res[k].peer_done   = ep_peer_closed;
            res[k].last_result = (k == n - 1);
            due_results.push_back((typed && k == 0) ? want : res[k]);
        end
    endtask

    task automatic offer_event(input t_item ev, input bit typed, input t_result want);
        int gap;
        bit acted;
        gap = in_calm ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_opcode       <= ev.opcode;
        i_pkt_seq      <= ev.pkt_seq;
        i_pkt_ack      <= ev.pkt_ack;
        i_pkt_ack_flag <= ev.pkt_ack_flag;
        i_pkt_fin_flag <= ev.pkt_fin_flag;
        i_pkt_short    <= ev.pkt_short;
        i_want_fin     <= ev.want_fin;
        do @(posedge i_clk); while (!o_ready);
        predict_event(ev, typed, want, acted);
        if (acted) acted_events++;
    endtask

    // only with the block drained, plus a wait for events still in flight
    task automatic write_timeout(input logic [TIME_W-1:0] value);
        i_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        ep_init_timeout = value;
    endtask

    task automatic add_row(input t_opcode op, input logic [SEQ_W-1:0] sq,
                           input logic [SEQ_W-1:0] ak, input logic af, input logic ff,
                           input logic sh, input logic wf, input bit typed,
                           input t_result want);
        t_script_row r;
        r.is_cfg          = 1'b0;
        r.cfg_val         = '0;
        r.ev.opcode       = op;
        r.ev.pkt_seq      = sq;
        r.ev.pkt_ack      = ak;
        r.ev.pkt_ack_flag = af;
        r.ev.pkt_fin_flag = ff;
        r.ev.pkt_short    = sh;
        r.ev.want_fin     = wf;
        r.typed           = typed;
        r.want            = want;
        script.push_back(r);
    endtask

    task automatic add_cfg(input logic [TIME_W-1:0] value);
        t_script_row r;
        r.is_cfg  = 1'b1;
        r.cfg_val = value;
        r.ev      = '0;
        r.typed   = 1'b0;
        r.want    = '0;
        script.push_back(r);
    endtask

    function automatic t_item noise_item();
        t_item ev;
        ev.opcode       = t_opcode'($urandom_range(0, 3));
        ev.pkt_seq      = $urandom;
        ev.pkt_ack      = $urandom;
        ev.pkt_ack_flag = 1'($urandom_range(0, 1));
        ev.pkt_fin_flag = 1'($urandom_range(0, 1));
        ev.pkt_short    = 1'($urandom_range(0, 1));
        ev.want_fin     = 1'($urandom_range(0, 1));
        return ev;
    endfunction

    task automatic send_episode();
        t_item ev;
        int    ticks;
        int    pick;
        ev = noise_item();
        ev.opcode = OP_SEND;
        offer_event(ev, 1'b0, '0);
        ticks = ($urandom_range(0, 39) == 0) ? $urandom_range(20, 300) : $urandom_range(0, 8);
        repeat (ticks) begin
            pick = $urandom_range(0, 9);
            ev = noise_item();
            if (pick < 7) begin
                ev.opcode = OP_TICK;
            end else if (pick == 7) begin
                // peer repeats the segment we last took: it missed our ack
                ev.opcode = OP_PKT;
                ev.pkt_seq = ep_expect_seq - 1'b1;
            end else if (pick == 8) begin
                ev.opcode = OP_PKT;
                ev.pkt_ack = ep_send_seq;
                ev.pkt_ack_flag = 1'b0;
            end else begin
                ev.opcode = ($urandom_range(0, 1) != 0) ? OP_SEND : OP_RECV;
            end
            offer_event(ev, 1'b0, '0);
        end
        ev = noise_item();
        ev.opcode = OP_PKT;
        ev.pkt_ack_flag = 1'b1;
        ev.pkt_ack = ep_send_seq;
        offer_event(ev, 1'b0, '0);
    endtask

    task automatic recv_episode();
        t_item ev;
        int    pick;
        bit    need_fin;
        ev = noise_item();
        ev.opcode = OP_RECV;
        need_fin = ev.want_fin;
        offer_event(ev, 1'b0, '0);
        repeat ($urandom_range(0, 4)) begin
            pick = $urandom_range(0, 4);
            ev = noise_item();
            ev.opcode = OP_PKT;
            case (pick)
                0: begin
                    ev.pkt_short = 1'b1;
                    ev.pkt_seq = ep_expect_seq;
                end
                1: begin
                    ev.pkt_short = 1'b0;
                    ev.pkt_seq = ep_expect_seq - 1'b1;
                end
                2: begin
                    // right number, fin clear: only taken when fin is not required
                    ev.pkt_short = 1'b0;
                    ev.pkt_seq = ep_expect_seq;
                    ev.pkt_fin_flag = 1'b0;
                end
                3: ev.opcode = OP_TICK;
                default: ;
            endcase
            offer_event(ev, 1'b0, '0);
        end
        ev = noise_item();
        ev.opcode = OP_PKT;
        ev.pkt_short = 1'b0;
        ev.pkt_seq = ep_expect_seq;
        if (need_fin) ev.pkt_fin_flag = 1'b1;
        offer_event(ev, 1'b0, '0);
    endtask

    task automatic flag_result(input string why, input string want_s, input t_result got);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%0t %s: expected %s, got %s", $time, why, want_s, show(got));
        end
    endtask

    // one transaction per result, with a stall drawn before each
    initial begin : result_sink
        int stall;
        i_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = out_calm ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_result got;
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            got.kind         = o_kind;
            got.out_seq      = o_out_seq;
            got.out_ack      = o_out_ack;
            got.out_ack_flag = o_out_ack_flag;
            got.out_fin_flag = o_out_fin_flag;
            got.rtt_now      = o_rtt_now;
            got.timeout_now  = o_timeout_now;
            got.peer_done    = o_peer_done;
            got.last_result  = o_last_result;
            if (due_results.size() == 0) begin
                flag_result("unexpected result", "nothing", got);
            end else begin
                want = due_results.pop_front();
                if (got.kind !== want.kind || got.out_seq !== want.out_seq
                        || got.out_ack !== want.out_ack
                        || got.out_ack_flag !== want.out_ack_flag
                        || got.out_fin_flag !== want.out_fin_flag
                        || got.rtt_now !== want.rtt_now
                        || got.timeout_now !== want.timeout_now
                        || got.peer_done !== want.peer_done
                        || got.last_result !== want.last_result) begin
                    flag_result("result mismatch", show(want), got);
                end
            end
        end
    end

    initial begin
        #5000000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        int                target;
        int                pick;
        logic [TIME_W-1:0] value;
        i_rst_n        = 1'b0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_wr_data  = '0;
        i_valid        = 1'b0;
        i_opcode       = OP_SEND;
        i_pkt_seq      = '0;
        i_pkt_ack      = '0;
        i_pkt_ack_flag = 1'b0;
        i_pkt_fin_flag = 1'b0;
        i_pkt_short    = 1'b0;
        i_want_fin     = 1'b0;

        ep_mode         = MODE_IDLE;
        ep_send_seq     = '0;
        ep_expect_seq   = '0;
        ep_srtt         = '0;
        ep_rttvar       = '0;
        ep_time_left    = '0;
        ep_interval     = '0;
        ep_init_timeout = INIT_TIMEOUT_RST;
        ep_samples      = '0;
        ep_retx         = 1'b0;
        ep_fin          = 1'b0;
        ep_peer_closed  = 1'b0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ignored events while idle
        add_row(OP_TICK, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0);
        add_row(OP_PKT, '1, '1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, '0);
        add_row(OP_SEND, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
                typed_result(KIND_SEGMENT, '0, '0, 1'b0, 1'b0, '0, INIT_TIMEOUT_RST, 1'b0));
        add_row(OP_SEND, '1, '1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, '0);
        // expect_seq - 1 wraps to all ones: re-ack of the duplicate
        add_row(OP_PKT, '1, '0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1,
                typed_result(KIND_ACK, '0, '1, 1'b1, 1'b0, '0, INIT_TIMEOUT_RST, 1'b0));
        add_row(OP_TICK, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0);
        // short header still completes the send
        add_row(OP_PKT, '1, '0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, '0);
        add_cfg(16'd1);
        add_row(OP_SEND, '0, '0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, '0);
        add_row(OP_TICK, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0);
        add_row(OP_PKT, '0, 32'd1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, '0);
        add_row(OP_RECV, '0, '0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, '0);
        add_row(OP_PKT, '0, '0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, '0);
        add_row(OP_PKT, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0);
        add_row(OP_PKT, '0, '1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, '0);
        add_row(OP_RECV, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0);
        add_row(OP_PKT, 32'd1, '0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0);
        add_cfg(TIME_MAX);
        add_row(OP_SEND, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0);
        add_row(OP_TICK, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0);
        add_row(OP_TICK, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0);
        add_row(OP_PKT, '0, 32'd2, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, '0);
        add_row(OP_SEND, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0);
        add_row(OP_PKT, '0, 32'd3, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, '0);
        // zero interval: the next tick retransmits
        add_row(OP_SEND, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0);
        add_row(OP_TICK, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0);
        add_row(OP_PKT, '0, 32'd4, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, '0);

        foreach (script[i]) begin
            if (script[i].is_cfg) begin
                write_timeout(script[i].cfg_val);
            end else begin
                offer_event(script[i].ev, script[i].typed, script[i].want);
            end
        end

        for (int phase = 0; phase < 5; phase++) begin
            value = (phase == 0) ? TIME_MAX : (phase == 1) ? TIME_W'(1)
                  : TIME_W'($urandom_range(1, 65535));
            write_timeout(value);
            // roughly one event in five is ignored, so this gives about 250 offered
            target = acted_events + 200;
            while (acted_events < target) begin
                if ($urandom_range(0, 15) == 0) begin
                    in_calm  = ($urandom_range(0, 2) == 0);
                    out_calm = ($urandom_range(0, 2) == 0);
                end
                pick = $urandom_range(0, 19);
                if (pick < 9) begin
                    send_episode();
                end else if (pick < 17) begin
                    recv_episode();
                end else begin
                    offer_event(noise_item(), 1'b0, '0);
                end
            end
        end

        i_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && due_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
